// File: src/wildcard_byte_pattern_scan_core_macros.svh
// Assertion macros shared by the wildcard byte pattern scan RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is asserted.
`define WBPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wbps assertion failed");

// Checked on every rising clock edge, reset included.
`define WBPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("wbps assertion failed");

`endif

// File: src/wbps_pkg.sv
// Package with constants and types of the wildcard byte pattern scan.
package wbps_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int WINDOW_BYTES = 2097152;
  localparam int BYTE_W       = 8;
  localparam int OFFSET_W     = $clog2(WINDOW_BYTES);
  localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W        = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PAT_BITS     = 16 * BYTE_W;

  localparam logic [BYTE_W-1:0] WILDCARD_RESET = 8'hCC;
  localparam logic [CNT_W-1:0]  CNT_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_WILDCARD       = 3'd3,
    CFG_OCCURRENCE     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              active;
    logic              wild;
    logic [BYTE_W-1:0] pat_byte;
  } cell_cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] occurrence;
  } scan_cfg_t;

endpackage

// File: src/wbps_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface wbps_in_if;
  import wbps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface wbps_out_if;
  import wbps_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

interface wbps_cfg_if;
  import wbps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/wbps_cfg.sv
// Configuration registers and per-cell pattern setup of the pattern scan.
module wbps_cfg (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  wbps_cfg_if.sink                                cfg_i,
  output wbps_pkg::cell_cfg_t [wbps_pkg::PATTERN_MAX-1:0] cell_cfg_o,
  output wbps_pkg::scan_cfg_t                     scan_cfg_o
);
  import wbps_pkg::*;

  logic [PAT_BITS-1:0] pattern_q, pattern_d;
  logic [LEN_W-1:0]    length_q, length_d;
  logic [BYTE_W-1:0]   wildcard_q, wildcard_d;
  logic [CNT_W-1:0]    occurrence_q, occurrence_d;
  logic [LEN_W-1:0]    len_used;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    pattern_d    = pattern_q;
    length_d     = length_q;
    wildcard_d   = wildcard_q;
    occurrence_d = occurrence_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PATTERN_LOW:    pattern_d[63:0]   = cfg_i.data;
        CFG_PATTERN_HIGH:   pattern_d[127:64] = cfg_i.data;
        CFG_PATTERN_LENGTH: length_d          = cfg_i.data[LEN_W-1:0];
        CFG_WILDCARD:       wildcard_d        = cfg_i.data[BYTE_W-1:0];
        CFG_OCCURRENCE:     occurrence_d      = cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= '0;
      length_q     <= LEN_W'(1);
      wildcard_q   <= WILDCARD_RESET;
      occurrence_q <= CNT_W'(1);
    end else begin
      pattern_q    <= pattern_d;
      length_q     <= length_d;
      wildcard_q   <= wildcard_d;
      occurrence_q <= occurrence_d;
    end
  end

  assign len_used = (length_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : length_q;

  // Cell k compares the byte k items ago and faces pattern byte len-1-k.
  always_comb begin
    logic [LEN_W-1:0] pidx;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pidx = len_used - LEN_W'(1) - LEN_W'(k);
      cell_cfg_o[k].active   = (LEN_W'(k) < len_used);
      cell_cfg_o[k].pat_byte = pattern_q[{pidx[IDX_W-1:0], 3'b000} +: BYTE_W];
      cell_cfg_o[k].wild     = (cell_cfg_o[k].pat_byte == wildcard_q);
    end
  end

  assign scan_cfg_o.len        = len_used;
  assign scan_cfg_o.occurrence = occurrence_q;

endmodule

// File: src/wbps_cell.sv
// One cell of the byte chain: holds a window byte and compares its input byte.
module wbps_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [wbps_pkg::BYTE_W-1:0] byte_i,
  input  wbps_pkg::cell_cfg_t         cfg_i,
  output logic [wbps_pkg::BYTE_W-1:0] byte_o,
  output logic                        hit_o
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  assign byte_d = en_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;
  assign hit_o  = !cfg_i.active || cfg_i.wild || (byte_i == cfg_i.pat_byte);

endmodule

// File: src/wildcard_byte_pattern_scan_core.sv
// Top level of the wildcard byte pattern scan with its chain of compare cells.
// The result caused by an item is registered, valid the cycle after it is accepted.
// Throughput: one item per cycle unless a pending result stalls the input; each item
// shifts the cell chain one byte and is compared with the whole pattern in that cycle.
// Reset clears the window position, match count, report flag and result valid flag;
// configuration returns to length 1, wildcard 0xCC and occurrence 1.
`include "wildcard_byte_pattern_scan_core_macros.svh"

module wildcard_byte_pattern_scan_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  wbps_cfg_if.sink   cfg_i,
  wbps_in_if.sink    in_i,
  wbps_out_if.source out_o
);
  import wbps_pkg::*;

  cell_cfg_t [PATTERN_MAX-1:0] cell_cfg;
  scan_cfg_t                   scan_cfg;
  logic [BYTE_W-1:0]           chain_in  [PATTERN_MAX];
  logic [BYTE_W-1:0]           chain_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      cell_hit;

  logic [OFFSET_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                done_q, done_d;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [OFFSET_W-1:0] out_offset_q, out_offset_d;

  logic             in_acc;
  logic             last;
  logic             hit;
  logic [CNT_W-1:0] count_inc;
  logic             emit_found;
  logic             emit_none;

  wbps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cell_cfg_o (cell_cfg),
    .scan_cfg_o (scan_cfg)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign chain_in[k] = in_i.data_byte;
    end else begin : g_body
      assign chain_in[k] = chain_out[k-1];
    end
    wbps_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (in_acc),
      .byte_i (chain_in[k]),
      .cfg_i  (cell_cfg[k]),
      .byte_o (chain_out[k]),
      .hit_o  (cell_hit[k])
    );
  end

  assign last = in_i.last_byte || (pos_q == OFFSET_W'(WINDOW_BYTES - 1));

  assign hit = !done_q && (scan_cfg.len != '0) &&
               (pos_q >= OFFSET_W'(scan_cfg.len - LEN_W'(1))) && (&cell_hit);

  assign count_inc  = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
  assign emit_found = hit && (scan_cfg.occurrence != '0) &&
                      (count_inc == scan_cfg.occurrence);
  assign emit_none  = last && !done_q && !emit_found;

  always_comb begin
    pos_d   = pos_q;
    count_d = count_q;
    done_d  = done_q;
    if (in_acc) begin
      if (last) begin
        pos_d   = '0;
        count_d = '0;
        done_d  = 1'b0;
      end else begin
        pos_d   = pos_q + OFFSET_W'(1);
        count_d = hit ? count_inc : count_q;
        done_d  = done_q || emit_found;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_offset_d = out_offset_q;
    if (in_acc && (emit_found || emit_none)) begin
      out_valid_d  = 1'b1;
      out_found_d  = emit_found;
      out_offset_d = emit_found ? pos_q - OFFSET_W'(scan_cfg.len - LEN_W'(1)) : '0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_offset_q <= out_offset_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.match_offset = out_offset_q;

  `WBPS_ASSERT_ALWAYS(a_pos_in_window, pos_q <= OFFSET_W'(WINDOW_BYTES - 1))
  `WBPS_ASSERT(a_no_report_after_done, (in_acc && done_q) |-> !emit_found)
  `WBPS_ASSERT(a_count_saturates, (in_acc && !last && count_q == CNT_MAX) |=> count_q == CNT_MAX)
  `WBPS_ASSERT(a_none_has_zero_offset, (out_valid_q && !out_found_q) |-> out_offset_q == '0)

endmodule
